>>> hdl/lrrc_pkg.sv
// Shared codes and types for the link recovery retry controller.
package lrrc_pkg;

    localparam int CFG_WIDTH    = 31;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;
    localparam int NOW_WIDTH    = 32;
    localparam int ERR_WIDTH    = 32;
    localparam int OUT_ATT_W    = 16;

    localparam logic [2:0] ACT_BEGIN   = 3'd0;
    localparam logic [2:0] ACT_STARTED = 3'd1;
    localparam logic [2:0] ACT_FAILED  = 3'd2;
    localparam logic [2:0] ACT_FRAME   = 3'd3;
    localparam logic [2:0] ACT_TICK    = 3'd4;
    localparam logic [2:0] ACT_SUSPEND = 3'd5;
    localparam logic [2:0] ACT_STOP    = 3'd6;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_READY   = 3'd2;
    localparam logic [2:0] CMD_ABORT   = 3'd3;
    localparam logic [2:0] CMD_GIVEUP  = 3'd4;

    localparam logic [2:0] ST_STREAMING = 3'd0;
    localparam logic [2:0] ST_CONNECTING = 3'd1;
    localparam logic [2:0] ST_AWAITING  = 3'd2;
    localparam logic [2:0] ST_ABORTING  = 3'd3;
    localparam logic [2:0] ST_RETRYWAIT = 3'd4;
    localparam logic [2:0] ST_FAILED    = 3'd5;
    localparam logic [2:0] ST_SUSPENDED = 3'd6;
    localparam logic [2:0] ST_STOPPED   = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_WINDOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECT_TIMEOUT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIMEOUT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_DELAY     = 8'd3;

    localparam logic [CFG_WIDTH-1:0] RST_RECOVERY_WINDOW = 31'd30000;
    localparam logic [CFG_WIDTH-1:0] RST_CONNECT_TIMEOUT = 31'd10000;
    localparam logic [CFG_WIDTH-1:0] RST_FRAME_TIMEOUT   = 31'd5000;
    localparam logic [CFG_WIDTH-1:0] RST_RETRY_DELAY     = 31'd1000;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] recovery_window;
        logic [CFG_WIDTH-1:0] connect_timeout;
        logic [CFG_WIDTH-1:0] frame_timeout;
        logic [CFG_WIDTH-1:0] retry_delay;
    } lrrc_cfg_t;

endpackage

>>> hdl/link_recovery_retry_controller_core.sv
// Top level of the link recovery retry controller: registers, config port, result stage.
//
// Usage: each input beat (action, now, error_code) is one timestamped event.
// Each accepted beat produces exactly one result beat (command, machine_state,
// last_error, attempt_count) showing the state after the event.
// Channels: in_* and out_* use valid/ready; cfg_* writes register cfg_index
// with the low 31 bits of cfg_data (0 recovery window, 1 connect timeout,
// 2 frame timeout, 3 retry delay; other indexes are dropped). cfg_ready is
// always high; write only while no event is in flight.
// The result is registered and appears in the cycle after the input beat is accepted.
// Throughput: one event per cycle while the result stage is not stalled; the state update is a single pass of
// adders and wrap-safe compares between the state registers and the result
// register.
// Stall: while out_valid is high and out_ready low, the result holds and
// in_ready drops; an event is accepted in the same cycle the held result
// is taken.
// Reset: state machine goes to streaming, deadlines, error and attempt
// count clear, config registers return to 30000/10000/5000/1000, the
// result stage empties.
module link_recovery_retry_controller_core
    import lrrc_pkg::*;
#(
    parameter int TIME_WIDTH    = 32,
    parameter int ATTEMPT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             action,
    input  logic [NOW_WIDTH-1:0]   now,
    input  logic [ERR_WIDTH-1:0]   error_code,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             command,
    output logic [2:0]             machine_state,
    output logic [ERR_WIDTH-1:0]   last_error,
    output logic [OUT_ATT_W-1:0]   attempt_count
);

    lrrc_cfg_t                cfg_reg;
    logic [2:0]               phase_reg;
    logic [TIME_WIDTH-1:0]    rec_dl_reg;
    logic [TIME_WIDTH-1:0]    phase_dl_reg;
    logic [TIME_WIDTH-1:0]    retry_tm_reg;
    logic [ERR_WIDTH-1:0]     err_reg;
    logic [ATTEMPT_WIDTH-1:0] att_reg;

    logic [2:0]               cmd_next;
    logic [2:0]               phase_next;
    logic [TIME_WIDTH-1:0]    rec_dl_next;
    logic [TIME_WIDTH-1:0]    phase_dl_next;
    logic [TIME_WIDTH-1:0]    retry_tm_next;
    logic [ERR_WIDTH-1:0]     err_next;
    logic [ATTEMPT_WIDTH-1:0] att_next;
    logic [47:0]              att_ext;

    logic                     out_valid_reg;
    logic [2:0]               cmd_out_reg;
    logic [2:0]               state_out_reg;
    logic [ERR_WIDTH-1:0]     err_out_reg;
    logic [OUT_ATT_W-1:0]     att_out_reg;

    logic                     in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_fire   = in_valid & in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.recovery_window <= RST_RECOVERY_WINDOW;
            cfg_reg.connect_timeout <= RST_CONNECT_TIMEOUT;
            cfg_reg.frame_timeout   <= RST_FRAME_TIMEOUT;
            cfg_reg.retry_delay     <= RST_RETRY_DELAY;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RECOVERY_WINDOW: cfg_reg.recovery_window <= cfg_data[CFG_WIDTH-1:0];
                REG_CONNECT_TIMEOUT: cfg_reg.connect_timeout <= cfg_data[CFG_WIDTH-1:0];
                REG_FRAME_TIMEOUT:   cfg_reg.frame_timeout   <= cfg_data[CFG_WIDTH-1:0];
                REG_RETRY_DELAY:     cfg_reg.retry_delay     <= cfg_data[CFG_WIDTH-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    lrrc_step #(
        .TIME_WIDTH    (TIME_WIDTH),
        .ATTEMPT_WIDTH (ATTEMPT_WIDTH)
    ) u_step (
        .cfg           (cfg_reg),
        .action        (action),
        .now           (now),
        .error_code    (error_code),
        .phase         (phase_reg),
        .rec_dl        (rec_dl_reg),
        .phase_dl      (phase_dl_reg),
        .retry_tm      (retry_tm_reg),
        .err           (err_reg),
        .att           (att_reg),
        .command       (cmd_next),
        .phase_next    (phase_next),
        .rec_dl_next   (rec_dl_next),
        .phase_dl_next (phase_dl_next),
        .retry_tm_next (retry_tm_next),
        .err_next      (err_next),
        .att_next      (att_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ST_STREAMING;
            rec_dl_reg   <= '0;
            phase_dl_reg <= '0;
            retry_tm_reg <= '0;
            err_reg      <= '0;
            att_reg      <= '0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            rec_dl_reg   <= rec_dl_next;
            phase_dl_reg <= phase_dl_next;
            retry_tm_reg <= retry_tm_next;
            err_reg      <= err_next;
            att_reg      <= att_next;
        end
    end

    assign att_ext = 48'(att_next);

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_out_reg   <= cmd_next;
            state_out_reg <= phase_next;
            err_out_reg   <= err_next;
            att_out_reg   <= att_ext[OUT_ATT_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign command       = cmd_out_reg;
    assign machine_state = state_out_reg;
    assign last_error    = err_out_reg;
    assign attempt_count = att_out_reg;

endmodule

>>> hdl/lrrc_step.sv
// Per-event next-state and command logic of the recovery state machine.
module lrrc_step
    import lrrc_pkg::*;
#(
    parameter int TIME_WIDTH    = 32,
    parameter int ATTEMPT_WIDTH = 16
)
(
    input  lrrc_cfg_t                cfg,
    input  logic [2:0]               action,
    input  logic [NOW_WIDTH-1:0]     now,
    input  logic [ERR_WIDTH-1:0]     error_code,
    input  logic [2:0]               phase,
    input  logic [TIME_WIDTH-1:0]    rec_dl,
    input  logic [TIME_WIDTH-1:0]    phase_dl,
    input  logic [TIME_WIDTH-1:0]    retry_tm,
    input  logic [ERR_WIDTH-1:0]     err,
    input  logic [ATTEMPT_WIDTH-1:0] att,
    output logic [2:0]               command,
    output logic [2:0]               phase_next,
    output logic [TIME_WIDTH-1:0]    rec_dl_next,
    output logic [TIME_WIDTH-1:0]    phase_dl_next,
    output logic [TIME_WIDTH-1:0]    retry_tm_next,
    output logic [ERR_WIDTH-1:0]     err_next,
    output logic [ATTEMPT_WIDTH-1:0] att_next
);

    logic [63:0]               now_ext;
    logic [TIME_WIDTH-1:0]     now_t;
    logic [TIME_WIDTH-1:0]     win_t;
    logic [TIME_WIDTH-1:0]     conn_t;
    logic [TIME_WIDTH-1:0]     frame_t;
    logic [TIME_WIDTH-1:0]     retry_t;
    logic [TIME_WIDTH-1:0]     neg_win;
    logic [TIME_WIDTH-1:0]     diff_rec;
    logic [TIME_WIDTH-1:0]     diff_phase;
    logic [TIME_WIDTH-1:0]     diff_retry;
    logic                      rec_hit;
    logic                      phase_hit;
    logic                      retry_hit;
    logic                      begin_hit;
    logic [ATTEMPT_WIDTH-1:0]  att_inc;

    assign now_ext = 64'(now);
    assign now_t   = now_ext[TIME_WIDTH-1:0];

    // window values widened (or cut) to the time width
    always_comb
    begin
        logic [63:0] w;
        logic [63:0] c;
        logic [63:0] f;
        logic [63:0] r;
        w = 64'(cfg.recovery_window);
        c = 64'(cfg.connect_timeout);
        f = 64'(cfg.frame_timeout);
        r = 64'(cfg.retry_delay);
        win_t   = w[TIME_WIDTH-1:0];
        conn_t  = c[TIME_WIDTH-1:0];
        frame_t = f[TIME_WIDTH-1:0];
        retry_t = r[TIME_WIDTH-1:0];
    end

    // wrap-safe deadline checks: reached when now - deadline is non-negative
    assign neg_win    = TIME_WIDTH'(0) - win_t;
    assign diff_rec   = now_t - rec_dl;
    assign diff_phase = now_t - phase_dl;
    assign diff_retry = now_t - retry_tm;
    assign begin_hit  = ~neg_win[TIME_WIDTH-1];
    assign rec_hit    = ~diff_rec[TIME_WIDTH-1];
    assign phase_hit  = ~diff_phase[TIME_WIDTH-1];
    assign retry_hit  = ~diff_retry[TIME_WIDTH-1];

    assign att_inc = (&att) ? att : att + ATTEMPT_WIDTH'(1);

    always_comb
    begin
        command       = CMD_NONE;
        phase_next    = phase;
        rec_dl_next   = rec_dl;
        phase_dl_next = phase_dl;
        retry_tm_next = retry_tm;
        err_next      = err;
        att_next      = att;
        case (action)
            ACT_BEGIN:
            begin
                if (phase == ST_STOPPED)
                begin
                    command = CMD_GIVEUP;
                end
                else
                begin
                    rec_dl_next = now_t + win_t;
                    err_next    = error_code;
                    if (begin_hit)
                    begin
                        phase_next = ST_FAILED;
                        att_next   = '0;
                        command    = CMD_GIVEUP;
                    end
                    else
                    begin
                        phase_next    = ST_CONNECTING;
                        phase_dl_next = now_t + conn_t;
                        att_next      = ATTEMPT_WIDTH'(1);
                        command       = CMD_START;
                    end
                end
            end
            ACT_STARTED:
            begin
                if (phase == ST_CONNECTING)
                begin
                    phase_next    = ST_AWAITING;
                    phase_dl_next = now_t + frame_t;
                end
            end
            ACT_FAILED:
            begin
                if (phase == ST_CONNECTING || phase == ST_AWAITING || phase == ST_ABORTING)
                begin
                    err_next = error_code;
                    if (rec_hit)
                    begin
                        phase_next = ST_FAILED;
                        command    = CMD_GIVEUP;
                    end
                    else
                    begin
                        phase_next    = ST_RETRYWAIT;
                        retry_tm_next = now_t + retry_t;
                    end
                end
            end
            ACT_FRAME:
            begin
                if (phase == ST_AWAITING)
                begin
                    phase_next    = ST_STREAMING;
                    rec_dl_next   = '0;
                    phase_dl_next = '0;
                    retry_tm_next = '0;
                    err_next      = '0;
                    att_next      = '0;
                    command       = CMD_READY;
                end
            end
            ACT_TICK:
            begin
                if (phase == ST_RETRYWAIT)
                begin
                    if (rec_hit)
                    begin
                        phase_next = ST_FAILED;
                        command    = CMD_GIVEUP;
                    end
                    else if (retry_hit)
                    begin
                        phase_next    = ST_CONNECTING;
                        phase_dl_next = now_t + conn_t;
                        att_next      = att_inc;
                        command       = CMD_START;
                    end
                end
                else if (phase == ST_CONNECTING || phase == ST_AWAITING)
                begin
                    if (phase_hit || rec_hit)
                    begin
                        phase_next = ST_ABORTING;
                        command    = CMD_ABORT;
                    end
                end
            end
            ACT_SUSPEND:
            begin
                if (phase != ST_STOPPED)
                begin
                    phase_next = ST_SUSPENDED;
                end
            end
            ACT_STOP:
            begin
                phase_next = ST_STOPPED;
            end
            default:
            begin
                command = CMD_NONE;
            end
        endcase
    end

endmodule
